### design/mhfe_pkg.sv
`default_nettype none

package mhfe_pkg;

    localparam int DEFAULT_COUNT_BITS = 24;
    localparam int BYTE_W = 8;
    localparam int LEN_W = 24;
    localparam int CFG_W = 24;
    localparam int CFG_IDX_W = 8;
    localparam int HDR_CNT_W = 25;
    localparam int KEY_LEN = 15;
    localparam int KEY_POS_W = 4;

    localparam logic [CFG_W-1:0] MAX_FRAME_RESET = 24'd1048576;
    localparam logic [CFG_W-1:0] RECV_BUF_RESET = 24'd2097152;
    localparam logic [LEN_W-1:0] LEN_MAX = 24'hFFFFFF;
    localparam logic [23:0] TERM_TAIL = 24'h0D0A0D;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RECV_BUF = 8'd1;

    localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_PLUS = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_ZERO = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE = 8'h39;

    typedef enum logic [1:0] {
        ST_DATA = 2'd0,
        ST_HDR_LONG = 2'd1,
        ST_FRAME_BIG = 2'd2,
        ST_BUF_OVF = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_PAYLOAD = 3'b010,
        PH_HALT = 3'b100
    } phase_t;

    typedef enum logic [3:0] {
        NUM_IDLE = 4'b0001,
        NUM_LEAD = 4'b0010,
        NUM_DIGITS = 4'b0100,
        NUM_DONE = 4'b1000
    } num_phase_t;

    typedef struct packed {
        logic [CFG_W-1:0] max_frame_bytes;
        logic [CFG_W-1:0] recv_buffer_bytes;
    } cfg_t;

    typedef struct packed {
        logic valid;
        logic [BYTE_W-1:0] data_byte;
        logic frame_last;
        logic [LEN_W-1:0] frame_length;
        status_t status;
    } result_t;

    function automatic logic [BYTE_W-1:0] key_char(input logic [KEY_POS_W-1:0] pos);
        logic [BYTE_W-1:0] c;
        unique case (pos)
            4'd0: c = 8'h43;
            4'd1: c = 8'h6F;
            4'd2: c = 8'h6E;
            4'd3: c = 8'h74;
            4'd4: c = 8'h65;
            4'd5: c = 8'h6E;
            4'd6: c = 8'h74;
            4'd7: c = 8'h2D;
            4'd8: c = 8'h4C;
            4'd9: c = 8'h65;
            4'd10: c = 8'h6E;
            4'd11: c = 8'h67;
            4'd12: c = 8'h74;
            4'd13: c = 8'h68;
            4'd14: c = 8'h3A;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic is_space(input logic [BYTE_W-1:0] b);
        return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
    endfunction

endpackage

`default_nettype wire

### design/mhfe_in_reg.sv
`default_nettype none

module mhfe_in_reg
    import mhfe_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [BYTE_W-1:0] s_tdata,
    input  wire logic              advance,
    output logic                   item_valid,
    output logic [BYTE_W-1:0]      item_byte
);

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] byte_reg;

    assign s_tready = !valid_reg || advance;
    assign valid_next = s_tready ? s_tvalid : valid_reg;
    assign item_valid = valid_reg;
    assign item_byte = byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            byte_reg <= s_tdata;
        end
    end

endmodule

`default_nettype wire

### design/mhfe_core.sv
`default_nettype none

module mhfe_core
    import mhfe_pkg::*;
#(
    parameter int COUNT_BITS = DEFAULT_COUNT_BITS
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire logic [BYTE_W-1:0] in_byte,
    input  wire cfg_t              cfg,
    output result_t                res
);

    localparam int LW = COUNT_BITS + 1;
    localparam int PW = LW + 4;
    localparam int CW = (LW > HDR_CNT_W + 1) ? LW : HDR_CNT_W + 1;
    localparam logic [LW-1:0] LEN_SAT = {1'b1, {COUNT_BITS{1'b0}}};

    phase_t                 phase_reg, phase_next;
    logic [23:0]            tail_reg, tail_next;
    logic [KEY_POS_W-1:0]   key_pos_reg, key_pos_next;
    num_phase_t             num_phase_reg, num_phase_next;
    logic                   neg_reg, neg_next;
    logic [LW-1:0]          acc_reg, acc_next;
    logic [HDR_CNT_W-1:0]   hdr_cnt_reg, hdr_cnt_next;
    logic [LEN_W-1:0]       left_reg, left_next;

    logic                   is_digit;
    logic [PW-1:0]          prod;
    logic [LW-1:0]          acc_step;
    logic [HDR_CNT_W-1:0]   hdr_inc;
    logic [CW-1:0]          len_w;
    logic [LEN_W-1:0]       len_clamp;

    assign is_digit = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
    assign prod = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1)
                + PW'(in_byte - CH_ZERO);
    assign acc_step = (prod > {4'b0, LEN_SAT}) ? LEN_SAT : prod[LW-1:0];
    assign hdr_inc = hdr_cnt_reg + 1'b1;
    assign len_w = CW'(acc_reg);
    assign len_clamp = (len_w > CW'(LEN_MAX)) ? LEN_MAX : len_w[LEN_W-1:0];

    always_comb
    begin
        phase_next = phase_reg;
        tail_next = tail_reg;
        key_pos_next = key_pos_reg;
        num_phase_next = num_phase_reg;
        neg_next = neg_reg;
        acc_next = acc_reg;
        hdr_cnt_next = hdr_cnt_reg;
        left_next = left_reg;
        res = '0;
        res.status = ST_DATA;

        if (step)
        begin
            unique case (phase_reg)
                PH_PAYLOAD:
                begin
                    res.valid = 1'b1;
                    res.data_byte = in_byte;
                    res.frame_last = (left_reg <= LEN_W'(1));
                    res.frame_length = len_clamp;
                    if (res.frame_last)
                    begin
                        phase_next = PH_HEADER;
                        tail_next = '0;
                        key_pos_next = '0;
                        num_phase_next = NUM_IDLE;
                        neg_next = 1'b0;
                        acc_next = '0;
                        hdr_cnt_next = '0;
                        left_next = '0;
                    end
                    else
                    begin
                        left_next = left_reg - 1'b1;
                    end
                end
                PH_HEADER:
                begin
                    hdr_cnt_next = hdr_inc;
                    unique case (num_phase_reg)
                        NUM_IDLE:
                        begin
                            if ((key_pos_reg < KEY_POS_W'(KEY_LEN))
                                && (in_byte == key_char(key_pos_reg)))
                            begin
                                key_pos_next = key_pos_reg + 1'b1;
                                if (key_pos_reg == KEY_POS_W'(KEY_LEN - 1))
                                begin
                                    num_phase_next = NUM_LEAD;
                                end
                            end
                            else
                            begin
                                key_pos_next = (in_byte == key_char('0)) ? KEY_POS_W'(1)
                                                                          : '0;
                            end
                        end
                        NUM_LEAD:
                        begin
                            priority if (is_space(in_byte))
                            begin
                                num_phase_next = NUM_LEAD;
                            end
                            else if ((in_byte == CH_PLUS) || (in_byte == CH_MINUS))
                            begin
                                neg_next = (in_byte == CH_MINUS);
                                num_phase_next = NUM_DIGITS;
                            end
                            else if (!is_digit)
                            begin
                                num_phase_next = NUM_DONE;
                            end
                            else
                            begin
                                num_phase_next = NUM_DIGITS;
                                acc_next = acc_step;
                            end
                        end
                        NUM_DIGITS:
                        begin
                            if (!is_digit)
                            begin
                                num_phase_next = NUM_DONE;
                            end
                            else
                            begin
                                acc_next = acc_step;
                            end
                        end
                        NUM_DONE:
                        begin
                            num_phase_next = NUM_DONE;
                        end
                        default:
                        begin
                            num_phase_next = num_phase_reg;
                        end
                    endcase

                    if ((tail_reg == TERM_TAIL) && (in_byte == CH_LF))
                    begin
                        priority if ((num_phase_next == NUM_IDLE) || neg_next
                                     || (acc_next == '0))
                        begin
                            phase_next = PH_HEADER;
                            tail_next = '0;
                            key_pos_next = '0;
                            num_phase_next = NUM_IDLE;
                            neg_next = 1'b0;
                            acc_next = '0;
                            hdr_cnt_next = '0;
                            left_next = '0;
                        end
                        else if (len_w > CW'(cfg.max_frame_bytes))
                        begin
                            phase_next = PH_HALT;
                            res.valid = 1'b1;
                            res.frame_length = len_clamp;
                            res.status = ST_FRAME_BIG;
                        end
                        else if ((CW'(hdr_inc) + len_w) > CW'(cfg.recv_buffer_bytes))
                        begin
                            phase_next = PH_HALT;
                            res.valid = 1'b1;
                            res.frame_length = len_clamp;
                            res.status = ST_BUF_OVF;
                        end
                        else
                        begin
                            phase_next = PH_PAYLOAD;
                            left_next = len_w[LEN_W-1:0];
                        end
                    end
                    else
                    begin
                        tail_next = {tail_reg[15:0], in_byte};
                        if (hdr_inc >= HDR_CNT_W'(cfg.recv_buffer_bytes))
                        begin
                            phase_next = PH_HALT;
                            res.valid = 1'b1;
                            res.status = ST_HDR_LONG;
                        end
                    end
                end
                PH_HALT:
                begin
                    phase_next = PH_HALT;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            tail_reg <= '0;
            key_pos_reg <= '0;
            num_phase_reg <= NUM_IDLE;
            neg_reg <= 1'b0;
            acc_reg <= '0;
            hdr_cnt_reg <= '0;
            left_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            tail_reg <= tail_next;
            key_pos_reg <= key_pos_next;
            num_phase_reg <= num_phase_next;
            neg_reg <= neg_next;
            acc_reg <= acc_next;
            hdr_cnt_reg <= hdr_cnt_next;
            left_reg <= left_next;
        end
    end

endmodule

`default_nettype wire

### design/mhfe_out_reg.sv
`default_nettype none

module mhfe_out_reg
    import mhfe_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire result_t  res,
    input  wire logic     advance,
    output logic          m_tvalid,
    output logic [31:0]   m_tdata,   // data_byte[7:0], frame_length[31:8]
    output logic          m_tlast,
    output logic [1:0]    m_tuser    // status[1:0]
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign valid_next = advance ? res.valid : valid_reg;
    assign m_tvalid = valid_reg;
    assign m_tdata = {res_reg.frame_length, res_reg.data_byte};
    assign m_tlast = res_reg.frame_last;
    assign m_tuser = res_reg.status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res.valid)
        begin
            res_reg <= res;
        end
    end

endmodule

`default_nettype wire

### design/mjpeg_http_frame_extractor.sv
`default_nettype none

// Splits an HTTP MJPEG multipart byte stream into frames. Each header, up to the first
// blank line, is scanned for its Content-Length value, and that many following bytes are
// sent out as payload with the length beside them and tlast on the final byte. A header
// without a positive length is dropped silently. An oversized header, a length above
// max_frame_bytes, or header plus payload above recv_buffer_bytes gives one error request
// (status in tuser, data byte zero) and the block then ignores all input until reset.
// One byte is taken every clock while the output is not stalled by m_tready; each byte
// passes an input register and then a result register before its result is presented.
// Configuration writes are always ready and should be made while the stream is idle.
module mjpeg_http_frame_extractor
    import mhfe_pkg::*;
#(
    parameter int COUNT_BITS = DEFAULT_COUNT_BITS
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           s_tdata,   // in_byte[7:0]
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [31:0]               m_tdata,   // data_byte[7:0], frame_length[31:8]
    output logic                      m_tlast,
    output logic [1:0]                m_tuser,   // status[1:0]
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    cfg_t              cfg_reg;
    logic              advance;
    logic              item_valid;
    logic [BYTE_W-1:0] item_byte;
    result_t           res;

    assign cfg_ready = 1'b1;
    assign advance = !m_tvalid || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_frame_bytes <= MAX_FRAME_RESET;
            cfg_reg.recv_buffer_bytes <= RECV_BUF_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_MAX_FRAME)
            begin
                cfg_reg.max_frame_bytes <= cfg_data;
            end
            else if (cfg_index == CFG_RECV_BUF)
            begin
                cfg_reg.recv_buffer_bytes <= cfg_data;
            end
        end
    end

    mhfe_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .advance    (advance),
        .item_valid (item_valid),
        .item_byte  (item_byte)
    );

    mhfe_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (item_valid && advance),
        .in_byte (item_byte),
        .cfg     (cfg_reg),
        .res     (res)
    );

    mhfe_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .res      (res),
        .advance  (advance),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire
